// File: hw/rtl/kpbc_pkg.sv
package kpbc_pkg;

	localparam int DigitW       = 6;
	localparam int DigitRegW    = 60;
	localparam int DigitRegs    = 3;
	localparam int PosW         = 48;
	localparam int LenW         = 5;
	localparam int ByteW        = 8;
	localparam int CfgIdxW      = 3;
	localparam logic [7:0] KeystreamMod = 8'd254;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_LOW   = 3'd0,
		REG_KEY_MID   = 3'd1,
		REG_KEY_HIGH  = 3'd2,
		REG_KEY_LEN   = 3'd3,
		REG_START_POS = 3'd4
	} cfg_reg_t;

	// one item as it travels down the cell row
	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
		logic [7:0]       pm;
		logic [7:0]       r;
	} kpbc_stage_t;

	// reduce a 15-bit value mod 254, using 256 == 2 (mod 254)
	function automatic logic [7:0] fold254(input logic [14:0] t);
		logic [8:0] u;
		u = {1'b0, t[7:0]} + {1'b0, t[14:8], 1'b0};
		if (u >= {1'b0, KeystreamMod}) u = u - {1'b0, KeystreamMod};
		if (u >= {1'b0, KeystreamMod}) u = u - {1'b0, KeystreamMod};
		return u[7:0];
	endfunction

	// position mod 254: byte i weighs 2^i
	function automatic logic [7:0] pos_mod254(input logic [PosW-1:0] p);
		logic [13:0] s;
		s = '0;
		for (int i = 0; i < PosW / 8; i++) begin
			s = s + (14'(p[8*i +: 8]) << i);
		end
		return fold254({1'b0, s});
	endfunction

endpackage

// File: hw/rtl/kpbc_in_if.sv
interface kpbc_in_if;
	import kpbc_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// File: hw/rtl/kpbc_out_if.sv
interface kpbc_out_if;
	import kpbc_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink (input valid, input result_byte, output ready);
endinterface

// File: hw/rtl/kpbc_cfg_if.sv
interface kpbc_cfg_if;
	import kpbc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CfgIdxW-1:0]   index;
	logic [DigitRegW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/keyed_position_byte_cipher.sv
// an accepted input passes through KEY_DIGITS-1 layer cells in a row
//   plus one output register before its result is valid
// throughput: one item per cycle; each cell of the row works one key layer
// the whole row stalls while a result waits on the output
// reset: key, key length, start position and position counter clear to zero,
//   pipeline empties; no clearing pass
module keyed_position_byte_cipher
	import kpbc_pkg::*;
#(
	parameter int KEY_DIGITS = 30
) (
	input logic        clk,
	input logic        arst_n,
	kpbc_in_if.sink    data_ch,
	kpbc_out_if.source result_ch,
	kpbc_cfg_if.sink   cfg_ch
);

	localparam int NumCells = KEY_DIGITS - 1;

	logic [DigitRegs-1:0][DigitRegW-1:0] key_q;
	logic [DigitRegs*DigitRegW-1:0]      digits;
	logic [LenW-1:0]                     len_q;
	logic [LenW-1:0]                     len_eff;
	logic [PosW-1:0]                     pos_q;
	logic [7:0]                          pm_q;
	logic                                en;
	logic                                accept;
	logic                                pos_load;
	kpbc_stage_t                         head;
	kpbc_stage_t                         stage_q [NumCells];
	logic                                out_valid_q;
	logic [ByteW-1:0]                    result_q;

	assign cfg_ch.ready = 1'b1;
	assign en           = !out_valid_q || result_ch.ready;
	assign data_ch.ready = en;
	assign accept       = data_ch.valid && en;
	assign pos_load     = cfg_ch.valid && (cfg_reg_t'(cfg_ch.index) == REG_START_POS);
	assign digits       = key_q;
	assign len_eff      = (len_q > LenW'(KEY_DIGITS)) ? LenW'(KEY_DIGITS) : len_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			len_q <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_reg_t'(cfg_ch.index))
				REG_KEY_LOW:  key_q[0] <= cfg_ch.data;
				REG_KEY_MID:  key_q[1] <= cfg_ch.data;
				REG_KEY_HIGH: key_q[2] <= cfg_ch.data;
				REG_KEY_LEN:  len_q <= cfg_ch.data[LenW-1:0];
				default: ;
			endcase
		end
	end

	// position counter and its residue mod 254
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pm_q  <= '0;
		end else if (pos_load) begin
			pos_q <= cfg_ch.data[PosW-1:0];
			pm_q  <= pos_mod254(cfg_ch.data[PosW-1:0]);
		end else if (accept) begin
			pos_q <= pos_q + PosW'(1);
			if (pos_q == {PosW{1'b1}} || pm_q == KeystreamMod - 8'd1) begin
				pm_q <= '0;
			end else begin
				pm_q <= pm_q + 8'd1;
			end
		end
	end

	// item entering the row, keystream starts at one
	always_comb begin
		head.valid = data_ch.valid;
		head.data  = data_ch.data_byte;
		head.pm    = pm_q;
		head.r     = 8'd1;
	end

	// row of layer cells
	for (genvar l = 0; l < NumCells; l++) begin : g_cell
		kpbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.active   ((LenW'(l) + LenW'(1)) < len_eff),
			.key_a    (digits[DigitW*l +: DigitW]),
			.key_b    (digits[DigitW*(l+1) +: DigitW]),
			.stage_in ((l == 0) ? head : stage_q[(l == 0) ? 0 : l-1]),
			.stage_q  (stage_q[l])
		);
	end

	// output register: 127 - data + (r - 127) reduces to r - data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else if (en) begin
			out_valid_q <= stage_q[NumCells-1].valid;
			result_q    <= stage_q[NumCells-1].r - stage_q[NumCells-1].data;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.result_byte = result_q;

	// accepted item shows up in the first cell
	a_head_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stage_q[0].valid)
		else $error("accepted item missing from first cell");

	// counter steps by one per accepted item
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pos_load) |=> pos_q == $past(pos_q) + PosW'(1))
		else $error("position counter did not advance");

	// residue stays reduced
	a_pm_range: assert property (@(posedge clk) disable iff (!arst_n)
		pm_q < KeystreamMod)
		else $error("position residue out of range");

	// a waiting result stalls the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_ch.ready) |-> !data_ch.ready)
		else $error("input taken while result stalled");

endmodule

// File: hw/rtl/kpbc_cell.sv
module kpbc_cell
	import kpbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              active,
	input  logic [DigitW-1:0] key_a,
	input  logic [DigitW-1:0] key_b,
	input  kpbc_stage_t       stage_in,
	output kpbc_stage_t       stage_q
);

	logic [DigitW:0] ka1;
	logic [14:0]     pa;
	logic [14:0]     pb;
	logic [14:0]     t;
	kpbc_stage_t     stage_d;

	// one key layer when active: r*(1+key_a) + pos*key_b, then mod 254; else r passes
	always_comb begin
		ka1     = {1'b0, key_a} + {{DigitW{1'b0}}, 1'b1};
		pa      = 15'(stage_in.r) * 15'(ka1);
		pb      = 15'(stage_in.pm) * 15'(key_b);
		t       = pa + pb;
		stage_d = stage_in;
		if (active) stage_d.r = fold254(t);
	end

	// hand the item to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (en) begin
			stage_q <= stage_d;
		end
	end

endmodule
